@@ rtl/core/dpeh_pkg.sv @@
// ----------------------------------------------------------------------------
// dpeh_pkg
// Shared types, constants, saturation helper, CORDIC arctangent table and the
// micro-program of the driven pendulum step unit.
// ----------------------------------------------------------------------------
package dpeh_pkg;

    localparam int DATA_W       = 48;
    localparam int HALF_W       = DATA_W / 2;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int FRAC_BITS    = 32;
    localparam int STEP_W       = 47;
    localparam int COUNT_W      = 24;
    localparam int CORDIC_ITERS = 32;
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_FRAC  = 60;
    localparam int CORDIC_SH    = CORDIC_FRAC - FRAC_BITS;
    localparam int IT_W         = $clog2(CORDIC_ITERS);
    // |angle| <= 2^47 (raw) and 2*pi*2^32*2^13 > 2^47, so 13 shift-subtract steps reduce it
    localparam int MOD_STEPS    = 13;
    localparam int MODK_W       = $clog2(MOD_STEPS);

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t QMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [CORDIC_W-1:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic signed [CORDIC_W-1:0] PI_Q60  = TWO_PI_Q60 / 2;
    localparam logic signed [CORDIC_W-1:0] HPI_Q60 = TWO_PI_Q60 / 4;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q60 = 64'sd700114967507363238;
    localparam logic [CORDIC_W-1:0] TWO_PI_F =
        (TWO_PI_Q60 + (64'd1 << (CORDIC_SH - 1))) >> CORDIC_SH;
    localparam logic signed [CORDIC_W-1:0] CORDIC_HALF = 64'sd1 <<< (CORDIC_SH - 1);

    // Reset values
    localparam q_t DAMPING_RST      = 48'sd85899346;
    localparam q_t NATURAL_FREQ_RST = 48'sd4294967296;
    localparam q_t DRIVE_AMP_RST    = 48'sd86758339;
    localparam q_t DRIVE_FREQ_RST   = 48'sd8589934592;
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 47'd42949673;
    localparam q_t START_ANGLE_RST  = 48'sd429496730;
    localparam logic [COUNT_W-1:0] TOTAL_STEPS_RST = 24'd100000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_FREQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_AMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FREQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STEPS  = 3'd6;

    function automatic logic signed [DATA_W+1:0] wide(input q_t v);
        return (DATA_W + 2)'(v);
    endfunction

    function automatic q_t sat_q(input logic signed [DATA_W+1:0] v);
        if (v > wide(QMAX)) begin
            return QMAX;
        end else if (v < wide(QMIN)) begin
            return QMIN;
        end
        return q_t'(v[DATA_W-1:0]);
    endfunction

    // arctan(2^-i) at 60 fraction bits: pi/4 for i = 0, else from the truncated alternating series
    function automatic logic signed [CORDIC_W-1:0] atan_entry(input int i);
        logic signed [CORDIC_W-1:0] sum;
        logic [CORDIC_W-1:0] num, rem, term, dv;
        int e, k, j;
        if (i == 0) begin
            return TWO_PI_Q60 >> 3;
        end
        sum = '0;
        k = 0;
        for (e = CORDIC_FRAC - i; e >= 0; e = e - 2 * i) begin
            num  = 64'd1 << e;
            dv   = 64'(2 * k + 1);
            rem  = '0;
            term = '0;
            for (j = CORDIC_W - 1; j >= 0; j--) begin
                rem = {rem[CORDIC_W-2:0], num[j]};
                if (rem >= dv) begin
                    rem     = rem - dv;
                    term[j] = 1'b1;
                end
            end
            sum = (k % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
            k++;
        end
        return sum;
    endfunction

    typedef logic [CORDIC_ITERS-1:0][CORDIC_W-1:0] atan_tab_t;

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t t;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            t[i] = atan_entry(i);
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // Micro-program
    typedef enum logic [1:0] {
        OP_ADD, OP_NSUB, OP_MUL, OP_SINCOS
    } op_t;

    typedef enum logic [4:0] {
        R_T, R_EV, R_EA, R_HV, R_HA,
        R_P, R_Q, R_K, R_SN, R_CS, R_A, R_FN, R_VP, R_XP, R_TN,
        R_W0, R_AMP, R_G, R_H, R_HH, R_DAMP2
    } reg_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t a;
        reg_sel_t b;
        reg_sel_t d;
    } uop_t;

    localparam int PROG_LEN = 49;
    localparam int PC_W     = $clog2(PROG_LEN);

    function automatic uop_t mk(input op_t op, input reg_sel_t a, input reg_sel_t b,
                                input reg_sel_t d);
        uop_t u;
        u.op = op;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // One force evaluation: d = -2*damping*v - (w0^2 + A*G^2*cos(G*t))*sin(x)
    function automatic uop_t accel_uop(input logic [3:0] idx, input reg_sel_t t,
                                       input reg_sel_t v, input reg_sel_t x,
                                       input reg_sel_t d);
        uop_t u;
        case (idx)
            4'd0:    u = mk(OP_MUL, R_G, t, R_P);
            4'd1:    u = mk(OP_SINCOS, R_P, R_P, R_P);
            4'd2:    u = mk(OP_MUL, R_W0, R_W0, R_K);
            4'd3:    u = mk(OP_MUL, R_AMP, R_G, R_Q);
            4'd4:    u = mk(OP_MUL, R_Q, R_G, R_Q);
            4'd5:    u = mk(OP_MUL, R_Q, R_CS, R_Q);
            4'd6:    u = mk(OP_ADD, R_K, R_Q, R_K);
            4'd7:    u = mk(OP_SINCOS, x, x, R_P);
            4'd8:    u = mk(OP_MUL, R_K, R_SN, R_Q);
            4'd9:    u = mk(OP_MUL, R_DAMP2, v, R_P);
            4'd10:   u = mk(OP_NSUB, R_P, R_Q, d);
            default: u = mk(OP_NSUB, R_P, R_Q, d);
        endcase
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_ADD, R_T, R_H, R_T);
        if (pc < PC_W'(11)) begin
            u = accel_uop(4'(pc), R_T, R_EV, R_EA, R_A);
        end else if (pc >= PC_W'(15) && pc < PC_W'(26)) begin
            u = accel_uop(4'(pc - PC_W'(15)), R_T, R_HV, R_HA, R_FN);
        end else if (pc >= PC_W'(31) && pc < PC_W'(42)) begin
            u = accel_uop(4'(pc - PC_W'(31)), R_TN, R_VP, R_XP, R_A);
        end else begin
            case (pc)
                PC_W'(11): u = mk(OP_MUL, R_H, R_A, R_Q);
                PC_W'(12): u = mk(OP_ADD, R_EV, R_Q, R_EV);
                PC_W'(13): u = mk(OP_MUL, R_H, R_EV, R_Q);
                PC_W'(14): u = mk(OP_ADD, R_EA, R_Q, R_EA);
                PC_W'(26): u = mk(OP_MUL, R_H, R_FN, R_Q);
                PC_W'(27): u = mk(OP_ADD, R_HV, R_Q, R_VP);
                PC_W'(28): u = mk(OP_MUL, R_H, R_HV, R_Q);
                PC_W'(29): u = mk(OP_ADD, R_HA, R_Q, R_XP);
                PC_W'(30): u = mk(OP_ADD, R_T, R_H, R_TN);
                PC_W'(42): u = mk(OP_ADD, R_HV, R_VP, R_Q);
                PC_W'(43): u = mk(OP_MUL, R_HH, R_Q, R_Q);
                PC_W'(44): u = mk(OP_ADD, R_HA, R_Q, R_HA);
                PC_W'(45): u = mk(OP_ADD, R_FN, R_A, R_Q);
                PC_W'(46): u = mk(OP_MUL, R_HH, R_Q, R_Q);
                PC_W'(47): u = mk(OP_ADD, R_HV, R_Q, R_HV);
                default:   u = mk(OP_ADD, R_T, R_H, R_T);
            endcase
        end
        return u;
    endfunction

endpackage

@@ rtl/core/dpeh_qmul.sv @@
// ----------------------------------------------------------------------------
// dpeh_qmul
// Multi-cycle fixed-point multiply: four half-width partial products, then
// round half away from zero and saturate.
// ----------------------------------------------------------------------------
module dpeh_qmul (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  dpeh_pkg::q_t  a,
    input  dpeh_pkg::q_t  b,
    output logic          done,
    output dpeh_pkg::q_t  res
);
    import dpeh_pkg::*;

    localparam int R_W = PROD_W - FRAC_BITS;

    logic [DATA_W-1:0] ua_reg, ub_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;

    logic [HALF_W-1:0] ax, by;
    logic [DATA_W-1:0] pp;
    logic [PROD_W-1:0] pp_sh, rnd;
    logic [R_W-1:0]    r;
    logic              big;

    always_comb begin
        ax    = cnt_reg[0] ? ua_reg[DATA_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        by    = cnt_reg[1] ? ub_reg[DATA_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        pp    = ax * by;
        pp_sh = PROD_W'(pp) << (HALF_W * (32'(cnt_reg[0]) + 32'(cnt_reg[1])));
        rnd   = acc_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        r     = rnd[PROD_W-1:FRAC_BITS];
        big   = |r[R_W-1:DATA_W-1];
        if (neg_reg) begin
            res = big ? QMIN : q_t'(-r[DATA_W-1:0]);
        end else begin
            res = big ? QMAX : q_t'(r[DATA_W-1:0]);
        end
        done = busy_reg && cnt_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg[2]) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
            ub_reg  <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            acc_reg <= '0;
        end else if (busy_reg && !cnt_reg[2]) begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

endmodule

@@ rtl/core/dpeh_sincos.sv @@
// ----------------------------------------------------------------------------
// dpeh_sincos
// Sine and cosine: reduce modulo 2*pi by shift-subtract, fold into
// [-pi/2, pi/2], then one CORDIC rotation per cycle.
// ----------------------------------------------------------------------------
module dpeh_sincos (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  dpeh_pkg::q_t  angle,
    output logic          done,
    output dpeh_pkg::q_t  sin_val,
    output dpeh_pkg::q_t  cos_val
);
    import dpeh_pkg::*;

    typedef enum logic [5:0] {
        SC_IDLE = 6'b000001,
        SC_MOD  = 6'b000010,
        SC_WRAP = 6'b000100,
        SC_FOLD = 6'b001000,
        SC_ROT  = 6'b010000,
        SC_DONE = 6'b100000
    } sc_state_t;

    sc_state_t state_reg, state_next;

    logic [DATA_W-1:0]          mag_reg;
    logic                       neg_reg, flip_reg;
    logic [MODK_W-1:0]          k_reg;
    logic [IT_W-1:0]            it_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;

    logic [CORDIC_W-1:0]        cmp;
    logic signed [CORDIC_W-1:0] z0, dx, dy, at, xf, sr, cr;

    always_comb begin
        cmp = TWO_PI_F << k_reg;
        z0  = $signed(CORDIC_W'(mag_reg)) <<< CORDIC_SH;
        if (neg_reg) begin
            z0 = -z0;
        end
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        at = $signed(ATAN_TAB[it_reg]);
        xf = flip_reg ? -x_reg : x_reg;
        sr = (y_reg + CORDIC_HALF) >>> CORDIC_SH;
        cr = (xf + CORDIC_HALF) >>> CORDIC_SH;
        sin_val = q_t'(sr[DATA_W-1:0]);
        cos_val = q_t'(cr[DATA_W-1:0]);
        done    = (state_reg == SC_DONE);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE: if (start) state_next = SC_MOD;
            SC_MOD:  if (k_reg == '0) state_next = SC_WRAP;
            SC_WRAP: state_next = SC_FOLD;
            SC_FOLD: state_next = SC_ROT;
            SC_ROT:  if (it_reg == IT_W'(CORDIC_ITERS - 1)) state_next = SC_DONE;
            SC_DONE: state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            SC_IDLE: begin
                mag_reg <= angle[DATA_W-1] ? DATA_W'(-angle) : DATA_W'(angle);
                neg_reg <= angle[DATA_W-1];
                k_reg   <= MODK_W'(MOD_STEPS - 1);
            end
            SC_MOD: begin
                if (CORDIC_W'(mag_reg) >= cmp) begin
                    mag_reg <= mag_reg - DATA_W'(cmp);
                end
                k_reg <= k_reg - MODK_W'(1);
            end
            SC_WRAP: begin
                if (z0 > PI_Q60) begin
                    z_reg <= z0 - $signed(TWO_PI_Q60);
                end else if (z0 < -PI_Q60) begin
                    z_reg <= z0 + $signed(TWO_PI_Q60);
                end else begin
                    z_reg <= z0;
                end
            end
            SC_FOLD: begin
                if (z_reg > HPI_Q60) begin
                    z_reg    <= PI_Q60 - z_reg;
                    flip_reg <= 1'b1;
                end else if (z_reg < -HPI_Q60) begin
                    z_reg    <= -PI_Q60 - z_reg;
                    flip_reg <= 1'b1;
                end else begin
                    flip_reg <= 1'b0;
                end
                x_reg  <= GAIN_Q60;
                y_reg  <= '0;
                it_reg <= '0;
            end
            SC_ROT: begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                it_reg <= it_reg + IT_W'(1);
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

endmodule

@@ rtl/core/driven_pendulum_euler_heun_step_unit.sv @@
// ----------------------------------------------------------------------------
// driven_pendulum_euler_heun_step_unit
// Damped pendulum with a parametrically driven pivot, integrated side by side
// by semi-implicit Euler and by Heun's predictor-corrector in Q16.32.
// ----------------------------------------------------------------------------
// Each input transfer is one command: restart (tdata bit 0 = 1) reloads t = 0,
// both angles from start_angle and both velocities at zero; a tick (bit 0 = 0)
// advances both trajectories by one step h. Every command yields exactly one
// output transfer carrying time, both angles, both velocities and done_res.
// Once total_steps steps are done, ticks hold the state and report done_res=1.
// A step runs a 49-entry micro-program over one shared multiplier and one
// shared sine/cosine unit: 27 multiplies, 6 sine/cosine evaluations (13
// reduction steps, a wrap and a fold step, 32 CORDIC rotations each) and 16
// adds. Restart and completed-run ticks skip the micro-program and go straight
// to the output. s_tready is low while a step runs; a finished result may wait
// in the output register while the next command is taken. Write configuration
// only while the block is idle; a new start_angle takes effect at the next
// restart.
// ----------------------------------------------------------------------------
module driven_pendulum_euler_heun_step_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] restart
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [47:0] sim_time, [95:48] euler_angle, [143:96] euler_velocity,
    // [191:144] heun_angle, [239:192] heun_velocity, [240] done_res
    output logic [247:0]                    m_tdata,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [dpeh_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [dpeh_pkg::DATA_W-1:0]     cfg_wdata
);
    import dpeh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration
    q_t damping_reg, natural_freq_reg, drive_amp_reg, drive_freq_reg, start_angle_reg;
    logic [STEP_W-1:0]  step_size_reg;
    logic [COUNT_W-1:0] total_steps_reg;

    // Trajectory state
    q_t t_reg, ev_reg, ea_reg, hv_reg, ha_reg;
    logic [COUNT_W-1:0] steps_reg;

    // Scratch registers of the micro-program
    q_t p_reg, q_reg, k_reg, sn_reg, cs_reg, a_reg, fn_reg, vp_reg, xp_reg, tn_reg;

    logic [PC_W-1:0] pc_reg;
    logic            m_tvalid_reg;
    logic [247:0]    m_tdata_reg;

    uop_t uop;
    q_t   a_val, b_val, alu_res, wr_val, damp2, mul_res, sc_sin, sc_cos;
    logic accept, restart, run_done, is_alu, wr_en, advance, last_uop;
    logic out_free, mul_start, mul_done, sc_start, sc_done;

    function automatic q_t sel_val(input reg_sel_t s, input q_t d2);
        q_t v;
        case (s)
            R_T:     v = t_reg;
            R_EV:    v = ev_reg;
            R_EA:    v = ea_reg;
            R_HV:    v = hv_reg;
            R_HA:    v = ha_reg;
            R_P:     v = p_reg;
            R_Q:     v = q_reg;
            R_K:     v = k_reg;
            R_SN:    v = sn_reg;
            R_CS:    v = cs_reg;
            R_A:     v = a_reg;
            R_FN:    v = fn_reg;
            R_VP:    v = vp_reg;
            R_XP:    v = xp_reg;
            R_TN:    v = tn_reg;
            R_W0:    v = natural_freq_reg;
            R_AMP:   v = drive_amp_reg;
            R_G:     v = drive_freq_reg;
            R_H:     v = q_t'({1'b0, step_size_reg});
            R_HH:    v = q_t'({2'b00, step_size_reg[STEP_W-1:1]});
            R_DAMP2: v = d2;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        uop      = uop_rom(pc_reg);
        damp2    = sat_q(wide(damping_reg) + wide(damping_reg));
        a_val    = sel_val(uop.a, damp2);
        b_val    = sel_val(uop.b, damp2);
        alu_res  = (uop.op == OP_NSUB) ? sat_q(-wide(a_val) - wide(b_val))
                                       : sat_q(wide(a_val) + wide(b_val));
        is_alu   = (uop.op == OP_ADD) || (uop.op == OP_NSUB);
        accept   = s_tvalid && s_tready;
        restart  = s_tdata[0];
        run_done = (steps_reg >= total_steps_reg);
        out_free = !m_tvalid_reg || m_tready;

        mul_start = (state_reg == ST_ISSUE) && (uop.op == OP_MUL);
        sc_start  = (state_reg == ST_ISSUE) && (uop.op == OP_SINCOS);

        // Write back: adds finish at issue, unit results when they report done
        wr_en    = ((state_reg == ST_ISSUE) && is_alu) || ((state_reg == ST_WAIT) && mul_done);
        wr_val   = (state_reg == ST_ISSUE) ? alu_res : mul_res;
        advance  = ((state_reg == ST_ISSUE) && is_alu)
                   || ((state_reg == ST_WAIT) && (mul_done || sc_done));
        last_uop = (pc_reg == PC_W'(PROG_LEN - 1));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    dpeh_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (a_val),
        .b       (b_val),
        .done    (mul_done),
        .res     (mul_res)
    );

    dpeh_sincos u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .angle   (a_val),
        .done    (sc_done),
        .sin_val (sc_sin),
        .cos_val (sc_cos)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (restart || run_done) ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (!is_alu) begin
                    state_next = ST_WAIT;
                end else if (last_uop) begin
                    state_next = ST_OUT;
                end
            end
            ST_WAIT: begin
                if (advance) begin
                    state_next = last_uop ? ST_OUT : ST_ISSUE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pc_reg <= '0;
            end else if (advance && !last_uop) begin
                pc_reg <= pc_reg + PC_W'(1);
            end
            // Load the result once the output register is free, drop it on transfer
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {7'd0, run_done, hv_reg, ha_reg, ev_reg, ea_reg, t_reg};
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg      <= DAMPING_RST;
            natural_freq_reg <= NATURAL_FREQ_RST;
            drive_amp_reg    <= DRIVE_AMP_RST;
            drive_freq_reg   <= DRIVE_FREQ_RST;
            step_size_reg    <= STEP_SIZE_RST;
            start_angle_reg  <= START_ANGLE_RST;
            total_steps_reg  <= TOTAL_STEPS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DAMPING:      damping_reg      <= q_t'(cfg_wdata);
                CFG_NATURAL_FREQ: natural_freq_reg <= q_t'(cfg_wdata);
                CFG_DRIVE_AMP:    drive_amp_reg    <= q_t'(cfg_wdata);
                CFG_DRIVE_FREQ:   drive_freq_reg   <= q_t'(cfg_wdata);
                CFG_STEP_SIZE:    step_size_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_START_ANGLE:  start_angle_reg  <= q_t'(cfg_wdata);
                CFG_TOTAL_STEPS:  total_steps_reg  <= cfg_wdata[COUNT_W-1:0];
                default:          total_steps_reg  <= total_steps_reg;
            endcase
        end
    end

    // Trajectory state: reload on restart, update from the micro-program
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg     <= '0;
            ev_reg    <= '0;
            ea_reg    <= START_ANGLE_RST;
            hv_reg    <= '0;
            ha_reg    <= START_ANGLE_RST;
            steps_reg <= '0;
        end else if (accept && restart) begin
            t_reg     <= '0;
            ev_reg    <= '0;
            ea_reg    <= start_angle_reg;
            hv_reg    <= '0;
            ha_reg    <= start_angle_reg;
            steps_reg <= '0;
        end else begin
            if (wr_en) begin
                case (uop.d)
                    R_T:     t_reg  <= wr_val;
                    R_EV:    ev_reg <= wr_val;
                    R_EA:    ea_reg <= wr_val;
                    R_HV:    hv_reg <= wr_val;
                    R_HA:    ha_reg <= wr_val;
                    default: t_reg  <= t_reg;
                endcase
            end
            if (advance && last_uop) begin
                steps_reg <= steps_reg + COUNT_W'(1);
            end
        end
    end

    // Scratch registers
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (uop.d)
                R_P:     p_reg  <= wr_val;
                R_Q:     q_reg  <= wr_val;
                R_K:     k_reg  <= wr_val;
                R_A:     a_reg  <= wr_val;
                R_FN:    fn_reg <= wr_val;
                R_VP:    vp_reg <= wr_val;
                R_XP:    xp_reg <= wr_val;
                R_TN:    tn_reg <= wr_val;
                default: p_reg  <= p_reg;
            endcase
        end
        if (state_reg == ST_WAIT && sc_done) begin
            sn_reg <= sc_sin;
            cs_reg <= sc_cos;
        end
    end

endmodule
